[sv/next_fit_bitmap_block_allocator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent checks for simulation; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define NEXT_FIT_BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define NFBA_ASSERT_IMP(lbl, clk_i, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define NFBA_ASSERT_NXT(lbl, clk_i, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NFBA_ASSERT_IMP(lbl, clk_i, rstn, ante, cons, msg)
`define NFBA_ASSERT_NXT(lbl, clk_i, rstn, ante, cons, msg)
`endif

`endif

[sv/nfba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit bitmap allocator package
// Widths, codes, controller states and the bit search helper.
// ----------------------------------------------------------------------------
package nfba_pkg;

	localparam int ID_W           = 10;   // block_id, granted_block, first_data_block
	localparam int DATA_W         = 16;   // tdata width, whole bytes
	localparam int WORD_W         = 32;   // bitmap memory word
	localparam int OFF_W          = 5;    // bit offset inside a word
	localparam int NUM_BLOCKS_DEF = 1024;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE_RD,
		S_FREE_WR,
		S_RESP
	} state_t;

	// Lowest set bit of a word.
	function automatic logic [OFF_W-1:0] first_one(input logic [WORD_W-1:0] v);
		logic [OFF_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = OFF_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

[sv/next_fit_bitmap_block_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-fit bitmap block allocator
// One used/free bit per block in a word-wide memory, with a rotating search
// pointer; allocate scans for the next free block, free clears a bit.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          tuser            tdata[9:0]
//  s_*       in   s_tvalid/s_tready  op (0 alloc)     block_id
//  m_*       out  m_tvalid/m_tready  status (1 full)  granted_block
//  cfg_*     in   cfg_wr_en          -                first_data_block (cfg_wr_data)
//
//  Allocate: one bitmap word read per cycle, from the pointer's word to the
//  last word, then from first_data_block's word back to the pointer's word.
//  Free: read-modify-write of one word, then the output register is loaded.
//  After reset the bitmap is swept to zero, one word a cycle, and no item is
//  taken meanwhile.
//  One item is in work at a time; a result waiting in the output register
//  does not block the next item, only the delivery of its result.
//
`include "next_fit_bitmap_block_allocator_unit_assert.svh"

module next_fit_bitmap_block_allocator_unit #(
	parameter int NUM_BLOCKS = nfba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Request items
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [nfba_pkg::DATA_W-1:0] s_tdata,     // [9:0] block_id, rest zero
	input  logic                        s_tuser,     // [0] op
	// Result items
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [nfba_pkg::DATA_W-1:0] m_tdata,     // [9:0] granted_block, rest zero
	output logic                        m_tuser,     // [0] status
	// Configuration: first_data_block
	input  logic                        cfg_wr_en,
	input  logic [nfba_pkg::ID_W-1:0]   cfg_wr_data
);

	import nfba_pkg::*;

	// Geometry of the bitmap memory
	localparam int WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	// Pointer wide enough for every block number and for first_data_block
	localparam int PW    = ($clog2(NUM_BLOCKS) > ID_W) ? $clog2(NUM_BLOCKS) : ID_W;
	localparam int TAIL  = NUM_BLOCKS - (WORDS - 1) * WORD_W;

	localparam logic [WA_W-1:0]   LAST_W    = WA_W'(WORDS - 1);
	localparam logic [WORD_W-1:0] TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - TAIL);
	localparam logic [PW:0]       NUM_X     = (PW + 1)'(NUM_BLOCKS);

	// Bitmap storage, one bit per block
	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] mem_rdata;
	logic              mem_re;
	logic [WA_W-1:0]   mem_raddr;
	logic              mem_we;
	logic [WA_W-1:0]   mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	// Control state
	state_t          state_q, state_d;
	logic [WA_W-1:0] clr_addr_q;
	logic [ID_W-1:0] fdb_q;
	logic [PW-1:0]   sp_q;
	logic            iss_act_q;
	logic            iss_ph_q;      // 0: pointer to top, 1: first data block to pointer
	logic [WA_W-1:0] iss_addr_q;
	logic            rd_vld_s1;
	logic            m_tvalid_q;

	// Item payload
	logic [PW-1:0]     p_q;
	logic [PW-1:0]     id_q;
	logic [WA_W-1:0]   rd_addr_s1;
	logic              rd_ph_s1;
	logic              res_status_q;
	logic [PW-1:0]     res_grant_q;
	logic              res_alloc_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	// Datapath signals
	logic              s_accept;
	logic              out_load;
	logic [PW-1:0]     fdb_ext;
	logic [PW-1:0]     id_ext;
	logic [PW-1:0]     p_wrap;
	logic              fdb_out;
	logic              id_in;
	logic [WA_W-1:0]   pw_word;
	logic [WA_W-1:0]   fd_word;
	logic [WA_W-1:0]   id_word;
	logic [OFF_W-1:0]  p_off;
	logic [OFF_W-1:0]  f_off;
	logic [WORD_W-1:0] mask_a;
	logic [WORD_W-1:0] mask_b;
	logic [WORD_W-1:0] free_v;
	logic              eval;
	logic              hit;
	logic              miss;
	logic [OFF_W-1:0]  hit_off;
	logic [PW-1:0]     grant_p;
	logic [PW:0]       grant_nxt;
	logic [PW-1:0]     sp_next;
	logic              grant_ok;

	assign s_accept = s_tvalid & s_tready;
	assign fdb_ext  = PW'(fdb_q);
	assign id_ext   = PW'(s_tdata[ID_W-1:0]);
	assign fdb_out  = {1'b0, fdb_ext} >= NUM_X;
	assign id_in    = {1'b0, id_ext} < NUM_X;
	// A pointer past the last block restarts at the first data block
	assign p_wrap   = ({1'b0, sp_q} >= NUM_X) ? fdb_ext : sp_q;

	assign pw_word  = p_q[OFF_W +: WA_W];
	assign p_off    = p_q[OFF_W-1:0];
	assign fd_word  = fdb_ext[OFF_W +: WA_W];
	assign f_off    = fdb_ext[OFF_W-1:0];
	assign id_word  = id_q[OFF_W +: WA_W];

	// Candidate bits of the word under test: first lap half from the pointer up
	// to the last block, second half from the first data block below the pointer
	always_comb begin
		mask_a = {WORD_W{1'b1}};
		mask_b = {WORD_W{1'b1}};
		if (rd_addr_s1 == pw_word) begin
			mask_a = mask_a & ({WORD_W{1'b1}} << p_off);
			mask_b = mask_b & ~({WORD_W{1'b1}} << p_off);
		end
		if (rd_addr_s1 == LAST_W) begin
			mask_a = mask_a & TAIL_MASK;
		end
		if (rd_addr_s1 == fd_word) begin
			mask_b = mask_b & ({WORD_W{1'b1}} << f_off);
		end
	end

	assign eval      = (state_q == S_SCAN) && rd_vld_s1;
	assign free_v    = ~mem_rdata & (rd_ph_s1 ? mask_b : mask_a);
	assign hit       = eval && (|free_v);
	assign miss      = eval && !hit && rd_ph_s1 && (rd_addr_s1 == pw_word);
	assign hit_off   = first_one(free_v);
	assign grant_p   = PW'({rd_addr_s1, hit_off});
	assign grant_nxt = {1'b0, grant_p} + (PW + 1)'(1);
	// Advance the pointer past the grant, wrapping to the first data block
	assign sp_next   = (grant_nxt >= NUM_X) ? fdb_ext : grant_nxt[PW-1:0];
	assign grant_ok  = {1'b0, res_grant_q} < NUM_X;

	// Next state, handshake and memory port control
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		out_load  = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = iss_addr_q;
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = mem_rdata;
		unique case (state_q)
			S_CLEAR: begin
				// Sweep the bitmap to all free
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == LAST_W) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == OP_FREE) begin
						state_d = id_in ? S_FREE_RD : S_RESP;
					end else begin
						state_d = fdb_out ? S_RESP : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				mem_re = iss_act_q;
				if (hit) begin
					// Claim the block in the word just read
					mem_we    = 1'b1;
					mem_wdata = mem_rdata | (WORD_W'(1) << hit_off);
					state_d   = S_RESP;
				end else if (miss) begin
					state_d = S_RESP;
				end
			end
			S_FREE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = id_word;
				state_d   = S_FREE_WR;
			end
			S_FREE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = id_word;
				mem_wdata = mem_rdata & ~(WORD_W'(1) << id_q[OFF_W-1:0]);
				state_d   = S_RESP;
			end
			S_RESP: begin
				// Hold the result until the output register is free
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			fdb_q      <= '0;
			sp_q       <= '0;
			iss_act_q  <= 1'b0;
			iss_ph_q   <= 1'b0;
			iss_addr_q <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + WA_W'(1);
			end

			// Start a scan at the pointer's word, first half of the lap
			if (s_accept && (s_tuser == OP_ALLOC)) begin
				iss_act_q  <= 1'b1;
				iss_ph_q   <= 1'b0;
				iss_addr_q <= p_wrap[OFF_W +: WA_W];
			end else if (state_q == S_SCAN) begin
				if (hit) begin
					iss_act_q <= 1'b0;
				end else if (iss_act_q) begin
					if (!iss_ph_q && (iss_addr_q == LAST_W)) begin
						iss_ph_q   <= 1'b1;
						iss_addr_q <= fd_word;
					end else if (iss_ph_q && (iss_addr_q == pw_word)) begin
						iss_act_q <= 1'b0;
					end else begin
						iss_addr_q <= iss_addr_q + WA_W'(1);
					end
				end
			end

			// Drop the read issued in the cycle of a hit
			rd_vld_s1 <= (state_q == S_SCAN) && iss_act_q && !hit;

			if (hit) begin
				sp_q <= sp_next;
			end
			// Register write also reloads the pointer
			if (cfg_wr_en) begin
				fdb_q <= cfg_wr_data;
				sp_q  <= PW'(cfg_wr_data);
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			p_q          <= p_wrap;
			id_q         <= id_ext;
			res_alloc_q  <= (s_tuser == OP_ALLOC);
			res_grant_q  <= '0;
			res_status_q <= ((s_tuser == OP_ALLOC) && fdb_out) ? ST_FULL : ST_DONE;
		end
		if (hit) begin
			res_grant_q <= grant_p;
		end
		if (miss) begin
			res_status_q <= ST_FULL;
		end
		rd_addr_s1 <= iss_addr_q;
		rd_ph_s1   <= iss_ph_q;
		if (out_load) begin
			m_tdata_q <= DATA_W'(res_grant_q[ID_W-1:0]);
			m_tuser_q <= res_status_q;
		end
	end

	// Bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata <= mem[mem_raddr];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// A scan always has a read in flight or being checked
	`NFBA_ASSERT_IMP(a_scan_live, clk, arst_n, state_q == S_SCAN, iss_act_q || rd_vld_s1,
		"allocator scan stalled with no read in flight")
	// An accepted item always starts work
	`NFBA_ASSERT_NXT(a_accept_busy, clk, arst_n, s_accept, state_q != S_IDLE,
		"accepted item left controller idle")
	// A granted block is a real block
	`NFBA_ASSERT_IMP(a_grant_range, clk, arst_n,
		(state_q == S_RESP) && res_alloc_q && (res_status_q == ST_DONE), grant_ok,
		"granted block beyond last block")

endmodule

[sim/tb_next_fit_bitmap_block_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the next-fit bitmap block allocator
// A fixed opening sequence with hand-computed grants, then random allocate and
// free traffic over several first_data_block settings. Other results are checked
// against a behavioral next-fit allocator kept in the bench. Backpressure and
// source gaps are randomized in three modes, with one long output stall.
// ----------------------------------------------------------------------------
module tb_next_fit_bitmap_block_allocator_unit;
	import nfba_pkg::*;

	localparam int NUM_BLOCKS   = NUM_BLOCKS_DEF;
	localparam int SETTLE_CYC   = 48;     // longest scan plus margin, also covers the clear sweep
	localparam int PHASE_ITEMS  = 270;
	localparam int STALL_AFTER  = 500;    // results delivered before the long output stall
	localparam int STALL_CYC    = 400;
	localparam int PLAN_LEN     = 24;
	localparam int NUM_PHASES   = 6;

	typedef struct packed {
		logic            status;
		logic [ID_W-1:0] blk_no;
	} grant_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// One row of the opening sequence: a request or a first_data_block write.
	// Where fixed is set, st/blk hold the hand-computed result.
	typedef struct packed {
		row_kind_t       kind;
		logic            op;
		logic [ID_W-1:0] arg;
		logic            fixed;
		logic            st;
		logic [ID_W-1:0] blk;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [DATA_W-1:0]   s_tdata = '0;      // [9:0] block_id, rest zero
	logic                s_tuser = OP_ALLOC; // [0] op
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;           // [9:0] granted_block, rest zero
	logic                m_tuser;           // [0] status
	logic                cfg_wr_en = 1'b0;
	logic [ID_W-1:0]     cfg_wr_data = '0;

	// Shadow allocator state
	logic                blk_used [NUM_BLOCKS];
	int unsigned         scan_ptr;
	int unsigned         base_blk;

	grant_t              pending_grants [$];
	int                  held_blocks [$];   // blocks the shadow allocator holds as used
	grant_t              oldest;
	int                  errors = 0;
	int                  src_idle_pct = 0;
	int                  snk_idle_pct = 0;
	int                  delivered = 0;
	int                  stall_left = 0;
	bit                  stall_done = 0;
	int                  n_grants = 0;
	int                  n_full = 0;
	int                  n_frees = 0;

	// Fixed opening sequence: reset state, both config extremes, full, wrap.
	plan_row_t directed_plan [PLAN_LEN] = '{
		'{ROW_CFG, OP_ALLOC, 10'd0,    1'b0, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b1, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd1023, 1'b0, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd512,  1'b0, ST_DONE, 10'd0},
		'{ROW_REQ, OP_FREE,  10'd1,    1'b1, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b0, ST_DONE, 10'd0},
		'{ROW_REQ, OP_FREE,  10'd1023, 1'b1, ST_DONE, 10'd0},
		'{ROW_REQ, OP_FREE,  10'd0,    1'b1, ST_DONE, 10'd0},
		'{ROW_CFG, OP_ALLOC, 10'd1023, 1'b0, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b1, ST_DONE, 10'd1023},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b1, ST_FULL, 10'd0},
		'{ROW_REQ, OP_FREE,  10'd2,    1'b1, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b1, ST_FULL, 10'd0},
		'{ROW_REQ, OP_FREE,  10'd1023, 1'b1, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b1, ST_DONE, 10'd1023},
		'{ROW_CFG, OP_ALLOC, 10'd1021, 1'b0, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b1, ST_DONE, 10'd1021},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b1, ST_DONE, 10'd1022},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b1, ST_FULL, 10'd0},
		'{ROW_REQ, OP_FREE,  10'd1021, 1'b1, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b0, ST_DONE, 10'd0},
		'{ROW_REQ, OP_FREE,  10'd1022, 1'b1, ST_DONE, 10'd0},
		'{ROW_REQ, OP_FREE,  10'd1023, 1'b1, ST_DONE, 10'd0},
		'{ROW_REQ, OP_ALLOC, 10'd0,    1'b0, ST_DONE, 10'd0}
	};

	// first_data_block per random phase; high values keep the range small so it fills.
	int unsigned phase_base [NUM_PHASES] = '{1000, 0, 1008, 960, 1023, 992};

	next_fit_bitmap_block_allocator_unit #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Pointer past the last block falls back to the first data block.
	function automatic int unsigned wrap_block(input int unsigned p);
		return (p >= NUM_BLOCKS) ? base_blk : p;
	endfunction

	// Next-fit allocator: free clears a bit, allocate scans one lap from the pointer.
	function automatic grant_t next_fit_grant(input logic op, input logic [ID_W-1:0] id);
		grant_t      g;
		int unsigned p;
		g.status = ST_DONE;
		g.blk_no = '0;
		if (op == OP_FREE) begin
			if (id < NUM_BLOCKS)
				blk_used[id] = 1'b0;
			return g;
		end
		g.status = ST_FULL;
		if (base_blk < NUM_BLOCKS) begin
			p = wrap_block(scan_ptr);
			for (int unsigned n = 0; n < NUM_BLOCKS - base_blk; n++) begin
				if (!blk_used[p]) begin
					blk_used[p] = 1'b1;
					g.status = ST_DONE;
					g.blk_no = p[ID_W-1:0];
					scan_ptr = wrap_block(p + 1);
					return g;
				end
				p = wrap_block(p + 1);
			end
		end
		return g;
	endfunction

	// Offer one request item, wait for the handshake, then queue its expected grant.
	task automatic issue_request(input logic op, input logic [ID_W-1:0] id,
			input logic fixed, input grant_t fixed_grant);
		grant_t g;
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= DATA_W'(id);
		do @(posedge clk); while (s_tready !== 1'b1);
		g = next_fit_grant(op, id);
		pending_grants.insert(pending_grants.size(), fixed ? fixed_grant : g);
		// Track held blocks so most frees name a block actually in use.
		if (op == OP_FREE) begin
			n_frees++;
			for (int i = held_blocks.size() - 1; i >= 0; i--)
				if (held_blocks[i] == id)
					held_blocks.delete(i);
		end else if (g.status == ST_FULL) begin
			n_full++;
		end else begin
			n_grants++;
			held_blocks.insert(held_blocks.size(), int'(g.blk_no));
		end
	endtask

	// Drop valid, let every result come back and the scan settle, then write the register.
	task automatic load_first_block(input logic [ID_W-1:0] value);
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		base_blk = value;
		scan_ptr = value;
	endtask

	// Result side: random backpressure, plus one long stall to back the block up.
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready)
			delivered++;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (delivered == STALL_AFTER && !stall_done) begin
			stall_done = 1'b1;
			stall_left = STALL_CYC;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Compare each delivered result with the oldest queued grant.
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_grants.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: status=%0d granted_block=%0d",
					$realtime, m_tuser, m_tdata);
			end else begin
				oldest = pending_grants.pop_front();
				if (m_tuser !== oldest.status) begin
					errors++;
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$realtime, oldest.status, m_tuser);
				end
				if (m_tdata !== DATA_W'(oldest.blk_no)) begin
					errors++;
					$display("%0t: granted_block mismatch: expected %0d, actual %0d",
						$realtime, oldest.blk_no, m_tdata);
				end
			end
		end
	end

	initial begin
		logic            op;
		logic [ID_W-1:0] id;
		int              r;
		grant_t          fixed_grant;

		for (int i = 0; i < NUM_BLOCKS; i++)
			blk_used[i] = 1'b0;
		scan_ptr = 0;
		base_blk = 0;

		// Hold reset, release on a clock edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Opening sequence: sender idles lightly, receiver heavily.
		src_idle_pct = 34;
		snk_idle_pct = 86;
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CFG) begin
				load_first_block(directed_plan[i].arg);
			end else begin
				fixed_grant.status = directed_plan[i].st;
				fixed_grant.blk_no = directed_plan[i].blk;
				issue_request(directed_plan[i].op, directed_plan[i].arg,
					directed_plan[i].fixed, fixed_grant);
			end
		end

		// Random phases: two per idle mode, the last pair with no idling at all.
		fixed_grant = '0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			load_first_block(phase_base[ph][ID_W-1:0]);
			unique case (ph / 2)
				0: begin
					src_idle_pct = 34;
					snk_idle_pct = 86;
				end
				1: begin
					src_idle_pct = 86;
					snk_idle_pct = 34;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Mostly allocations and frees of held blocks; some frees of any block.
				r  = $urandom_range(99);
				id = ID_W'($urandom_range(NUM_BLOCKS - 1));
				if (r < 60) begin
					op = OP_ALLOC;
				end else begin
					op = OP_FREE;
					if (r < 92 && held_blocks.size() > 0)
						id = ID_W'(held_blocks[$urandom_range(held_blocks.size() - 1)]);
				end
				issue_request(op, id, 1'b0, fixed_grant);
			end
		end

		// Drain: every grant back, then a scan's worth of quiet cycles.
		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		$display("Checked %0d requests: %0d grants, %0d full reports, %0d frees.",
			n_grants + n_full + n_frees, n_grants, n_full, n_frees);
		$display("first_data_block ran at 0, 1021, 1023 and %0d random settings.", NUM_PHASES);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: reports a timeout and fails the run.
	initial begin
		#8_000_000;
		$display("Timeout with %0d results outstanding", pending_grants.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
